>>> rtl/sltc_pkg.sv
`default_nettype none

package sltc_pkg;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAGE_W = 24;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SEL_W   = 4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [SEL_W-1:0] SEL_WDCTL = 4'd0;
  localparam logic [SEL_W-1:0] SEL_CNT0  = 4'd1;
  localparam logic [SEL_W-1:0] SEL_CNT1  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_CNT2  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_CNT3  = 4'd4;
  localparam logic [SEL_W-1:0] SEL_LOAD  = 4'd5;
  localparam logic [SEL_W-1:0] SEL_CAP0  = 4'd6;
  localparam logic [SEL_W-1:0] SEL_CAP1  = 4'd7;
  localparam logic [SEL_W-1:0] SEL_CAP2  = 4'd8;
  localparam logic [SEL_W-1:0] SEL_CAP3  = 4'd9;

  localparam logic [BYTE_W-1:0] LOAD_DONE = 8'd1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [STAGE_W-1:0] stage_t;

endpackage

`default_nettype wire

>>> rtl/sltc_if.sv
`default_nettype none

interface sltc_in_if
  import sltc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [SEL_W-1:0]   reg_sel;
  logic [BYTE_W-1:0]  wdata;

  modport source (output valid, output cmd, output reg_sel, output wdata, input ready);
  modport sink   (input valid, input cmd, input reg_sel, input wdata, output ready);
endinterface

interface sltc_out_if
  import sltc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  rdata;
  logic               irq_pulse;

  modport source (output valid, output rdata, output irq_pulse, input ready);
  modport sink   (input valid, input rdata, input irq_pulse, output ready);
endinterface

`default_nettype wire

>>> rtl/sleep_timer_compare_peripheral.sv
// Sleep timer with a 32-bit compare that is loaded one byte at a time.
// Each word on in_bus is a timer tick, a register read or a register write.
// Every accepted word yields exactly one word on out_bus, carrying the read
// byte (zero for ticks and writes) and the compare-match interrupt pulse.
// A word is accepted when valid and ready are both high at a rising edge.
// The result is loaded into the output register at the edge that accepts the
// word. Throughput is one word per cycle while out_bus.ready stays high, set
// by the single increment and 32-bit compare between the state registers and
// the output register. in_bus.ready is high whenever the output register is
// empty or is being drained in the same cycle, so a stalled receiver holds
// the pending result and back-pressures the input after one word.
// Reset (rst_n low at a rising edge) clears the counter, the capture, the
// staged and loaded compare value and the armed match, and empties the
// output register.
`default_nettype none

module sleep_timer_compare_peripheral
  import sltc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  sltc_in_if.sink     in_bus,
  sltc_out_if.source  out_bus
);

  cnt_t   counter_r, counter_nxt;
  cnt_t   captured_r, captured_nxt;
  stage_t stage_r, stage_nxt;
  cnt_t   compare_r, compare_nxt;
  logic   armed_r, armed_nxt;
  logic   fire_next_r, fire_next_nxt;

  logic   out_valid_r;
  byte_t  rdata_r, rdata_nxt;
  logic   irq_r, irq_nxt;

  logic   acc;
  cnt_t   cnt_inc;
  cnt_t   new_compare;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign acc           = in_bus.valid && in_bus.ready;
  assign cnt_inc       = counter_r + cnt_t'(1);
  assign new_compare   = {stage_r, in_bus.wdata};

  always_comb begin
    counter_nxt   = counter_r;
    captured_nxt  = captured_r;
    stage_nxt     = stage_r;
    compare_nxt   = compare_r;
    armed_nxt     = armed_r;
    fire_next_nxt = fire_next_r;
    rdata_nxt     = '0;
    irq_nxt       = 1'b0;
    unique case (in_bus.cmd)
      CMD_TICK: begin
        counter_nxt = cnt_inc;
        if (armed_r && (fire_next_r || cnt_inc == compare_r)) begin
          irq_nxt       = 1'b1;
          armed_nxt     = 1'b0;
          fire_next_nxt = 1'b0;
        end
      end
      CMD_READ: begin
        unique case (in_bus.reg_sel)
          SEL_CNT0: begin
            captured_nxt = counter_r;
            rdata_nxt    = counter_r[7:0];
          end
          SEL_CNT1, SEL_CAP1: rdata_nxt = captured_r[15:8];
          SEL_CNT2, SEL_CAP2: rdata_nxt = captured_r[23:16];
          SEL_CNT3, SEL_CAP3: rdata_nxt = captured_r[31:24];
          SEL_CAP0:           rdata_nxt = captured_r[7:0];
          SEL_LOAD:           rdata_nxt = LOAD_DONE;
          default:            rdata_nxt = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (in_bus.reg_sel)
          SEL_CNT0: begin
            compare_nxt   = new_compare;
            armed_nxt     = 1'b1;
            fire_next_nxt = (new_compare == counter_r);
          end
          SEL_CNT1: stage_nxt[7:0]   = in_bus.wdata;
          SEL_CNT2: stage_nxt[15:8]  = in_bus.wdata;
          SEL_CNT3: stage_nxt[23:16] = in_bus.wdata;
          default:  stage_nxt        = stage_r;
        endcase
      end
      default: rdata_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r   <= '0;
      captured_r  <= '0;
      stage_r     <= '0;
      compare_r   <= '0;
      armed_r     <= 1'b0;
      fire_next_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        counter_r   <= counter_nxt;
        captured_r  <= captured_nxt;
        stage_r     <= stage_nxt;
        compare_r   <= compare_nxt;
        armed_r     <= armed_nxt;
        fire_next_r <= fire_next_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r <= rdata_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.rdata     = rdata_r;
  assign out_bus.irq_pulse = irq_r;

  // The next-tick flag only has meaning while a match is armed.
  a_fire_next_armed: assert property (@(posedge clk) disable iff (!rst_n)
    fire_next_r |-> armed_r)
    else $error("fire-next flag set without an armed match");

  // A match that fires is one-shot.
  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && irq_nxt) |=> !armed_r)
    else $error("match still armed after firing");

  // An accepted tick advances the counter by exactly one.
  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_bus.cmd == CMD_TICK) |=> (counter_r == $past(counter_r) + cnt_t'(1)))
    else $error("counter did not advance on a tick");

  // The output register never drops a pending word while the receiver stalls.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(rdata_r) && $stable(irq_r)))
    else $error("pending result changed during a stall");

endmodule

`default_nettype wire
